// ----- design/dlr_pkg.sv -----
`timescale 1ns / 1ps

package dlr_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;
  localparam int COLOR_BITS = 8;

  // coordinate differences need one extra bit
  localparam int DELTA_BITS = COORD_BITS + 1;
  // minor accumulator: sign guard + integer + fraction
  localparam int ACC_BITS   = COORD_BITS + FRAC_BITS + 1;
  // |slope| <= 1, so fraction + one integer bit + sign
  localparam int SLOPE_BITS = FRAC_BITS + 2;
  // quotient magnitude never exceeds 2^FRAC_BITS
  localparam int QUO_BITS   = FRAC_BITS + 1;
  localparam int CNT_BITS   = $clog2(QUO_BITS);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic {
    KIND_START   = 1'b0,
    KIND_ADVANCE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef struct packed {
    kind_t                          kind;
    logic                           steep;
    logic signed [COORD_BITS-1:0]   maj0;
    logic signed [COORD_BITS-1:0]   maj1;
    logic signed [COORD_BITS-1:0]   min0;
    logic signed [SLOPE_BITS-1:0]   slope;
    logic [COLOR_BITS-1:0]          red;
    logic [COLOR_BITS-1:0]          green;
    logic [COLOR_BITS-1:0]          blue;
  } line_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

// ----- design/dlr_front.sv -----
`timescale 1ns / 1ps

module dlr_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_kind,
  input  logic signed [dlr_pkg::COORD_BITS-1:0] in_x_start,
  input  logic signed [dlr_pkg::COORD_BITS-1:0] in_y_start,
  input  logic signed [dlr_pkg::COORD_BITS-1:0] in_x_end,
  input  logic signed [dlr_pkg::COORD_BITS-1:0] in_y_end,
  input  logic [dlr_pkg::COLOR_BITS-1:0]        in_color_red,
  input  logic [dlr_pkg::COLOR_BITS-1:0]        in_color_green,
  input  logic [dlr_pkg::COLOR_BITS-1:0]        in_color_blue,
  input  dlr_pkg::fifo_status_t                 q_status,
  output logic                                  q_push,
  output dlr_pkg::line_cmd_t                    q_cmd
);
  import dlr_pkg::*;

  front_state_t state_r, state_nxt;

  logic                         steep_r, steep_nxt;
  logic signed [COORD_BITS-1:0] maj0_r, maj0_nxt;
  logic signed [COORD_BITS-1:0] maj1_r, maj1_nxt;
  logic signed [COORD_BITS-1:0] min0_r, min0_nxt;
  logic [COORD_BITS-1:0]        dmaj_r, dmaj_nxt;
  logic                         neg_r, neg_nxt;
  logic                         lsb_r, lsb_nxt;
  logic [COORD_BITS-1:0]        rem_r, rem_nxt;
  logic [QUO_BITS-1:0]          quo_r, quo_nxt;
  logic [CNT_BITS-1:0]          cnt_r, cnt_nxt;
  logic [COLOR_BITS-1:0]        red_r, red_nxt;
  logic [COLOR_BITS-1:0]        green_r, green_nxt;
  logic [COLOR_BITS-1:0]        blue_r, blue_nxt;

  logic signed [DELTA_BITS-1:0] dx, dy, adx_full, ady_full;
  logic [COORD_BITS-1:0]        adx, ady;
  logic                         steep_c;
  logic                         accept;
  logic                         div_bit;
  logic [COORD_BITS:0]          trial;
  logic                         trial_ge;
  logic [SLOPE_BITS-1:0]        quo_ext;

  // classify the endpoints: major axis and stepping direction
  always_comb begin
    dx = {in_x_end[COORD_BITS-1], in_x_end} - {in_x_start[COORD_BITS-1], in_x_start};
    dy = {in_y_end[COORD_BITS-1], in_y_end} - {in_y_start[COORD_BITS-1], in_y_start};
    adx_full = dx[DELTA_BITS-1] ? -dx : dx;
    ady_full = dy[DELTA_BITS-1] ? -dy : dy;
    adx = adx_full[COORD_BITS-1:0];
    ady = ady_full[COORD_BITS-1:0];
    steep_c = !(adx > ady);
  end

  // one restoring division step per cycle
  always_comb begin
    div_bit  = (cnt_r == '0) ? lsb_r : 1'b0;
    trial    = {rem_r, div_bit};
    trial_ge = (trial >= {1'b0, dmaj_r});
    quo_ext  = {1'b0, quo_r};
  end

  always_comb begin
    state_nxt = state_r;
    steep_nxt = steep_r;
    maj0_nxt  = maj0_r;
    maj1_nxt  = maj1_r;
    min0_nxt  = min0_r;
    dmaj_nxt  = dmaj_r;
    neg_nxt   = neg_r;
    lsb_nxt   = lsb_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    cnt_nxt   = cnt_r;
    red_nxt   = red_r;
    green_nxt = green_r;
    blue_nxt  = blue_r;

    in_stall = (state_r != F_IDLE) || q_status.full;
    accept   = in_valid && !in_stall;
    q_push   = 1'b0;

    q_cmd.kind  = KIND_START;
    q_cmd.steep = steep_r;
    q_cmd.maj0  = maj0_r;
    q_cmd.maj1  = maj1_r;
    q_cmd.min0  = min0_r;
    q_cmd.slope = neg_r ? -quo_ext : quo_ext;
    q_cmd.red   = red_r;
    q_cmd.green = green_r;
    q_cmd.blue  = blue_r;

    case (state_r)
      F_IDLE: begin
        if (accept) begin
          if (kind_t'(in_kind) == KIND_ADVANCE) begin
            q_push     = 1'b1;
            q_cmd.kind = KIND_ADVANCE;
          end else begin
            steep_nxt = steep_c;
            if (steep_c) begin
              maj0_nxt = dy[DELTA_BITS-1] ? in_y_end   : in_y_start;
              maj1_nxt = dy[DELTA_BITS-1] ? in_y_start : in_y_end;
              min0_nxt = dy[DELTA_BITS-1] ? in_x_end   : in_x_start;
              dmaj_nxt = ady;
              rem_nxt  = adx >> 1;
              lsb_nxt  = adx[0];
            end else begin
              maj0_nxt = dx[DELTA_BITS-1] ? in_x_end   : in_x_start;
              maj1_nxt = dx[DELTA_BITS-1] ? in_x_start : in_x_end;
              min0_nxt = dx[DELTA_BITS-1] ? in_y_end   : in_y_start;
              dmaj_nxt = adx;
              rem_nxt  = ady >> 1;
              lsb_nxt  = ady[0];
            end
            neg_nxt   = dx[DELTA_BITS-1] ^ dy[DELTA_BITS-1];
            quo_nxt   = '0;
            cnt_nxt   = '0;
            red_nxt   = in_color_red;
            green_nxt = in_color_green;
            blue_nxt  = in_color_blue;
            // zero-length line: no division, slope stays zero
            if (adx == '0 && ady == '0) begin
              state_nxt = F_PUSH;
            end else begin
              state_nxt = F_DIV;
            end
          end
        end
      end
      F_DIV: begin
        rem_nxt = trial_ge ? COORD_BITS'(trial - {1'b0, dmaj_r}) : trial[COORD_BITS-1:0];
        quo_nxt = {quo_r[QUO_BITS-2:0], trial_ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_BITS'(QUO_BITS - 1)) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_status.full) begin
          q_push    = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    steep_r <= steep_nxt;
    maj0_r  <= maj0_nxt;
    maj1_r  <= maj1_nxt;
    min0_r  <= min0_nxt;
    dmaj_r  <= dmaj_nxt;
    neg_r   <= neg_nxt;
    lsb_r   <= lsb_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    cnt_r   <= cnt_nxt;
    red_r   <= red_nxt;
    green_r <= green_nxt;
    blue_r  <= blue_nxt;
  end

endmodule

// ----- design/dlr_queue.sv -----
`timescale 1ns / 1ps

module dlr_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  dlr_pkg::line_cmd_t    push_data,
  input  logic                  pop,
  output dlr_pkg::line_cmd_t    head,
  output dlr_pkg::fifo_status_t status
);
  import dlr_pkg::*;

  line_cmd_t          entries_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]   count_r, count_nxt;

  always_comb begin
    status.full  = (count_r == (FIFO_AW + 1)'(FIFO_DEPTH));
    status.empty = (count_r == '0);
    head         = entries_r[rd_ptr_r];

    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- design/dlr_back.sv -----
`timescale 1ns / 1ps

module dlr_back (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  dlr_pkg::line_cmd_t                    head,
  input  dlr_pkg::fifo_status_t                 q_status,
  output logic                                  q_pop,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [dlr_pkg::COORD_BITS-1:0] out_pixel_x,
  output logic signed [dlr_pkg::COORD_BITS-1:0] out_pixel_y,
  output logic [dlr_pkg::COLOR_BITS-1:0]        out_pixel_red,
  output logic [dlr_pkg::COLOR_BITS-1:0]        out_pixel_green,
  output logic [dlr_pkg::COLOR_BITS-1:0]        out_pixel_blue,
  output logic                                  out_last_point
);
  import dlr_pkg::*;

  logic                         active_r, active_nxt;
  logic                         steep_r, steep_nxt;
  logic signed [COORD_BITS-1:0] pos_r, pos_nxt;
  logic signed [COORD_BITS-1:0] lim_r, lim_nxt;
  logic signed [ACC_BITS-1:0]   acc_r, acc_nxt;
  logic signed [SLOPE_BITS-1:0] slope_r, slope_nxt;
  logic [COLOR_BITS-1:0]        red_r, red_nxt;
  logic [COLOR_BITS-1:0]        green_r, green_nxt;
  logic [COLOR_BITS-1:0]        blue_r, blue_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic signed [COORD_BITS-1:0] px_r, px_nxt;
  logic signed [COORD_BITS-1:0] py_r, py_nxt;
  logic [COLOR_BITS-1:0]        ored_r, ored_nxt;
  logic [COLOR_BITS-1:0]        ogreen_r, ogreen_nxt;
  logic [COLOR_BITS-1:0]        oblue_r, oblue_nxt;
  logic                         olast_r, olast_nxt;

  logic                         is_start, emit;
  logic                         cur_steep;
  logic signed [COORD_BITS-1:0] cur_pos, cur_lim, minor;
  logic signed [ACC_BITS-1:0]   cur_acc;
  logic signed [SLOPE_BITS-1:0] cur_slope;
  logic                         last, round_up;
  logic [COORD_BITS:0]          acc_int;

  always_comb begin
    is_start  = (head.kind == KIND_START);
    emit      = is_start || active_r;
    q_pop     = !q_status.empty && (!out_valid_r || !out_stall);

    cur_steep = is_start ? head.steep : steep_r;
    cur_pos   = is_start ? head.maj0  : pos_r;
    cur_lim   = is_start ? head.maj1  : lim_r;
    cur_slope = is_start ? head.slope : slope_r;
    cur_acc   = is_start ? {head.min0[COORD_BITS-1], head.min0, {FRAC_BITS{1'b0}}} : acc_r;

    // truncate toward zero: floor, then bump negatives with a fraction
    acc_int  = cur_acc[ACC_BITS-1:FRAC_BITS];
    round_up = cur_acc[ACC_BITS-1] && (cur_acc[FRAC_BITS-1:0] != '0);
    minor    = acc_int[COORD_BITS-1:0] + COORD_BITS'(round_up);
    last     = (cur_pos >= cur_lim);

    active_nxt = active_r;
    steep_nxt  = steep_r;
    pos_nxt    = pos_r;
    lim_nxt    = lim_r;
    acc_nxt    = acc_r;
    slope_nxt  = slope_r;
    red_nxt    = red_r;
    green_nxt  = green_r;
    blue_nxt   = blue_r;

    px_nxt     = px_r;
    py_nxt     = py_r;
    ored_nxt   = ored_r;
    ogreen_nxt = ogreen_r;
    oblue_nxt  = oblue_r;
    olast_nxt  = olast_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (q_pop) begin
      if (is_start) begin
        steep_nxt = head.steep;
        lim_nxt   = head.maj1;
        slope_nxt = head.slope;
        red_nxt   = head.red;
        green_nxt = head.green;
        blue_nxt  = head.blue;
      end
      if (emit) begin
        out_valid_nxt = 1'b1;
        px_nxt     = cur_steep ? minor : cur_pos;
        py_nxt     = cur_steep ? cur_pos : minor;
        ored_nxt   = is_start ? head.red : red_r;
        ogreen_nxt = is_start ? head.green : green_r;
        oblue_nxt  = is_start ? head.blue : blue_r;
        olast_nxt  = last;
        active_nxt = !last;
        pos_nxt    = cur_pos + 1'b1;
        acc_nxt    = cur_acc + {{(ACC_BITS - SLOPE_BITS){cur_slope[SLOPE_BITS-1]}}, cur_slope};
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    steep_r  <= steep_nxt;
    pos_r    <= pos_nxt;
    lim_r    <= lim_nxt;
    acc_r    <= acc_nxt;
    slope_r  <= slope_nxt;
    red_r    <= red_nxt;
    green_r  <= green_nxt;
    blue_r   <= blue_nxt;
    px_r     <= px_nxt;
    py_r     <= py_nxt;
    ored_r   <= ored_nxt;
    ogreen_r <= ogreen_nxt;
    oblue_r  <= oblue_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = px_r;
  assign out_pixel_y     = py_r;
  assign out_pixel_red   = ored_r;
  assign out_pixel_green = ogreen_r;
  assign out_pixel_blue  = oblue_r;
  assign out_last_point  = olast_r;

endmodule

// ----- design/dda_line_rasterizer_unit.sv -----
// advance transaction: queue write on acceptance, then back-end pickup into the output register;
//   one pixel per cycle sustained while the receiver does not stall
// start transaction: one-bit-per-cycle slope division in the front end, then a queue write
//   and back-end pickup into the output register; a zero-length line skips the division
// the front end stalls its input while it divides and pushes a start, so starts run one at a time
// reset (rst_n low, synchronous): queue emptied, no line active, output register empty
`timescale 1ns / 1ps

module dda_line_rasterizer_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_kind,
  input  logic signed [dlr_pkg::COORD_BITS-1:0] in_x_start,
  input  logic signed [dlr_pkg::COORD_BITS-1:0] in_y_start,
  input  logic signed [dlr_pkg::COORD_BITS-1:0] in_x_end,
  input  logic signed [dlr_pkg::COORD_BITS-1:0] in_y_end,
  input  logic [dlr_pkg::COLOR_BITS-1:0]        in_color_red,
  input  logic [dlr_pkg::COLOR_BITS-1:0]        in_color_green,
  input  logic [dlr_pkg::COLOR_BITS-1:0]        in_color_blue,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [dlr_pkg::COORD_BITS-1:0] out_pixel_x,
  output logic signed [dlr_pkg::COORD_BITS-1:0] out_pixel_y,
  output logic [dlr_pkg::COLOR_BITS-1:0]        out_pixel_red,
  output logic [dlr_pkg::COLOR_BITS-1:0]        out_pixel_green,
  output logic [dlr_pkg::COLOR_BITS-1:0]        out_pixel_blue,
  output logic                                  out_last_point
);
  import dlr_pkg::*;

  // front end -> queue: classified commands (start with finished slope, or advance)
  logic         q_push;
  line_cmd_t    q_cmd;
  // queue -> back end: oldest command and fill status
  line_cmd_t    q_head;
  fifo_status_t q_status;
  logic         q_pop;

  // accepts transactions, sorts endpoints by major axis, runs the slope divider
  dlr_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_x_start     (in_x_start),
    .in_y_start     (in_y_start),
    .in_x_end       (in_x_end),
    .in_y_end       (in_y_end),
    .in_color_red   (in_color_red),
    .in_color_green (in_color_green),
    .in_color_blue  (in_color_blue),
    .q_status       (q_status),
    .q_push         (q_push),
    .q_cmd          (q_cmd)
  );

  // short command queue so each side can stall independently
  dlr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_cmd),
    .pop       (q_pop),
    .head      (q_head),
    .status    (q_status)
  );

  // holds the line state, steps the minor accumulator and drives the output register;
  // an advance with no active line is consumed without a result
  dlr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (q_head),
    .q_status        (q_status),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_red   (out_pixel_red),
    .out_pixel_green (out_pixel_green),
    .out_pixel_blue  (out_pixel_blue),
    .out_last_point  (out_last_point)
  );

  // never write a full queue
  assert property (@(posedge clk) disable iff (!rst_n) !(q_push && q_status.full))
    else $error("command queue overflow");

  // never read an empty queue
  assert property (@(posedge clk) disable iff (!rst_n) !(q_pop && q_status.empty))
    else $error("command queue underflow");

  // an accepted advance goes straight into the queue in the same cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_kind == KIND_ADVANCE) |-> q_push)
    else $error("advance transaction lost in front end");

endmodule

// ----- bench/dda_pixel_checker.sv -----
`timescale 1ns / 1ps

module dda_pixel_checker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  logic                                  in_stall,
  input  logic                                  in_kind,
  input  logic signed [dlr_pkg::COORD_BITS-1:0] in_x_start,
  input  logic signed [dlr_pkg::COORD_BITS-1:0] in_y_start,
  input  logic signed [dlr_pkg::COORD_BITS-1:0] in_x_end,
  input  logic signed [dlr_pkg::COORD_BITS-1:0] in_y_end,
  input  logic [dlr_pkg::COLOR_BITS-1:0]        in_color_red,
  input  logic [dlr_pkg::COLOR_BITS-1:0]        in_color_green,
  input  logic [dlr_pkg::COLOR_BITS-1:0]        in_color_blue,
  input  logic                                  out_valid,
  input  logic                                  out_stall,
  input  logic signed [dlr_pkg::COORD_BITS-1:0] out_pixel_x,
  input  logic signed [dlr_pkg::COORD_BITS-1:0] out_pixel_y,
  input  logic [dlr_pkg::COLOR_BITS-1:0]        out_pixel_red,
  input  logic [dlr_pkg::COLOR_BITS-1:0]        out_pixel_green,
  input  logic [dlr_pkg::COLOR_BITS-1:0]        out_pixel_blue,
  input  logic                                  out_last_point,
  output int                                    mismatch_count,
  output int                                    pixels_pending,
  output int                                    pixels_checked
);
  import dlr_pkg::*;

  typedef struct {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic [COLOR_BITS-1:0]        red;
    logic [COLOR_BITS-1:0]        green;
    logic [COLOR_BITS-1:0]        blue;
    logic                         last;
  } pixel_t;

  pixel_t expected_pixels[$];

  // line walker state
  logic                         line_busy;
  logic                         steep;
  logic signed [COORD_BITS-1:0] major_pos;
  logic signed [COORD_BITS-1:0] major_end;
  logic signed [ACC_BITS-1:0]   minor_acc;
  logic signed [SLOPE_BITS-1:0] slope;
  logic [COLOR_BITS-1:0]        line_red;
  logic [COLOR_BITS-1:0]        line_green;
  logic [COLOR_BITS-1:0]        line_blue;

  function automatic void plot_pixel();
    pixel_t p;
    longint minor;
    // signed division truncates toward zero
    minor   = longint'(minor_acc) / (longint'(1) << FRAC_BITS);
    p.x     = steep ? COORD_BITS'(minor) : major_pos;
    p.y     = steep ? major_pos : COORD_BITS'(minor);
    p.red   = line_red;
    p.green = line_green;
    p.blue  = line_blue;
    p.last  = (major_pos >= major_end);
    expected_pixels.push_back(p);
    if (p.last) begin
      line_busy = 1'b0;
    end else begin
      line_busy = 1'b1;
      major_pos = major_pos + 1'b1;
      minor_acc = minor_acc + ACC_BITS'(slope);
    end
  endfunction

  function automatic void start_line(logic signed [COORD_BITS-1:0] xs,
                                     logic signed [COORD_BITS-1:0] ys,
                                     logic signed [COORD_BITS-1:0] xe,
                                     logic signed [COORD_BITS-1:0] ye,
                                     logic [COLOR_BITS-1:0] r,
                                     logic [COLOR_BITS-1:0] g,
                                     logic [COLOR_BITS-1:0] b);
    longint dx, dy, adx, ady, maj0, maj1, min0, dmaj, dmin;
    dx  = longint'(xe) - longint'(xs);
    dy  = longint'(ye) - longint'(ys);
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    if (adx > ady) begin
      steep = 1'b0;
      if (dx < 0) begin
        maj0 = longint'(xe); maj1 = longint'(xs); min0 = longint'(ye);
        dmaj = -dx; dmin = -dy;
      end else begin
        maj0 = longint'(xs); maj1 = longint'(xe); min0 = longint'(ys);
        dmaj = dx; dmin = dy;
      end
    end else begin
      // ties and zero-length lines walk in y
      steep = 1'b1;
      if (dy < 0) begin
        maj0 = longint'(ye); maj1 = longint'(ys); min0 = longint'(xe);
        dmaj = -dy; dmin = -dx;
      end else begin
        maj0 = longint'(ys); maj1 = longint'(ye); min0 = longint'(xs);
        dmaj = dy; dmin = dx;
      end
    end
    slope      = (dmaj == 0) ? '0 : SLOPE_BITS'((dmin * (longint'(1) << FRAC_BITS)) / dmaj);
    major_pos  = COORD_BITS'(maj0);
    major_end  = COORD_BITS'(maj1);
    minor_acc  = ACC_BITS'(min0 * (longint'(1) << FRAC_BITS));
    line_red   = r;
    line_green = g;
    line_blue  = b;
    plot_pixel();
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    pixel_t p;
    if (!rst_n) begin
      line_busy  = 1'b0;
      steep      = 1'b0;
      major_pos  = '0;
      major_end  = '0;
      minor_acc  = '0;
      slope      = '0;
      line_red   = '0;
      line_green = '0;
      line_blue  = '0;
      expected_pixels.delete();
    end else begin
      if (in_valid && !in_stall) begin
        if (in_kind == KIND_START)
          start_line(in_x_start, in_y_start, in_x_end, in_y_end,
                     in_color_red, in_color_green, in_color_blue);
        else if (line_busy)
          plot_pixel();
      end
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          $error("pixel (%0d,%0d) with none expected", out_pixel_x, out_pixel_y);
          mismatch_count++;
        end else begin
          p = expected_pixels.pop_front();
          check_field("pixel_x", p.x, out_pixel_x);
          check_field("pixel_y", p.y, out_pixel_y);
          check_field("pixel_red", p.red, out_pixel_red);
          check_field("pixel_green", p.green, out_pixel_green);
          check_field("pixel_blue", p.blue, out_pixel_blue);
          check_field("last_point", p.last, out_last_point);
          pixels_checked++;
        end
      end
    end
    pixels_pending = expected_pixels.size();
  end

endmodule

// ----- bench/tb_dda_line_rasterizer_unit.sv -----
`timescale 1ns / 1ps

module tb_dda_line_rasterizer_unit;
  import dlr_pkg::*;

  localparam int ITEM_TARGET    = 1550;
  // cycles with no transaction on either side before the run is abandoned
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 40;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic                         in_kind;
  logic signed [COORD_BITS-1:0] in_x_start;
  logic signed [COORD_BITS-1:0] in_y_start;
  logic signed [COORD_BITS-1:0] in_x_end;
  logic signed [COORD_BITS-1:0] in_y_end;
  logic [COLOR_BITS-1:0]        in_color_red;
  logic [COLOR_BITS-1:0]        in_color_green;
  logic [COLOR_BITS-1:0]        in_color_blue;
  logic                         out_valid;
  logic                         out_stall;
  logic signed [COORD_BITS-1:0] out_pixel_x;
  logic signed [COORD_BITS-1:0] out_pixel_y;
  logic [COLOR_BITS-1:0]        out_pixel_red;
  logic [COLOR_BITS-1:0]        out_pixel_green;
  logic [COLOR_BITS-1:0]        out_pixel_blue;
  logic                         out_last_point;

  int mismatch_count;
  int pixels_pending;
  int pixels_checked;

  // idle and stall odds in percent, changed per phase
  int send_idle_pct;
  int stall_pct;
  int starts_sent;
  int advances_sent;
  int quiet_cycles;

  dda_line_rasterizer_unit dut (.*);

  // watches both channels, predicts every pixel and compares
  dda_pixel_checker pixel_check (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver back-pressure, changes on the falling edge
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog: no transaction on either side for too long means a hang
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $error("no transaction for %0d cycles", quiet_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // one transaction: optional idle gap, then hold the payload until accepted
  task automatic send_item(kind_t kind,
                           logic signed [COORD_BITS-1:0] xs,
                           logic signed [COORD_BITS-1:0] ys,
                           logic signed [COORD_BITS-1:0] xe,
                           logic signed [COORD_BITS-1:0] ye,
                           logic [COLOR_BITS-1:0] r,
                           logic [COLOR_BITS-1:0] g,
                           logic [COLOR_BITS-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_x_start     <= xs;
    in_y_start     <= ys;
    in_x_end       <= xe;
    in_y_end       <= ye;
    in_color_red   <= r;
    in_color_green <= g;
    in_color_blue  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (kind == KIND_START)
      starts_sent++;
    else
      advances_sent++;
    @(negedge clk);
  endtask

  // advance ignores its payload, so fill it with junk
  task automatic send_advance();
    send_item(KIND_ADVANCE, COORD_BITS'($urandom), COORD_BITS'($urandom),
              COORD_BITS'($urandom), COORD_BITS'($urandom),
              COLOR_BITS'($urandom), COLOR_BITS'($urandom), COLOR_BITS'($urandom));
  endtask

  task automatic draw_line(int xs, int ys, int xe, int ye, int r, int g, int b, int steps);
    send_item(KIND_START, COORD_BITS'(xs), COORD_BITS'(ys), COORD_BITS'(xe),
              COORD_BITS'(ye), COLOR_BITS'(r), COLOR_BITS'(g), COLOR_BITS'(b));
    repeat (steps) send_advance();
  endtask

  // full range, with the extremes weighted up
  function automatic int rand_coord();
    case ($urandom_range(7))
      0:       return -2048;
      1:       return 2047;
      default: return int'($signed(COORD_BITS'($urandom)));
    endcase
  endfunction

  // a coordinate a short distance away, folded back into range
  function automatic int near_coord(int base);
    int off;
    int v;
    off = int'($urandom_range(48)) - 24;
    v   = base + off;
    if (v > 2047 || v < -2048)
      v = base - off;
    return v;
  endfunction

  // a well-formed line with random content; mostly walked to the end,
  // sometimes cut short by the next start or run past its end
  task automatic random_line();
    int xs, ys, xe, ye, d, adx, ady, pixels, steps;
    xs = rand_coord();
    ys = rand_coord();
    case ($urandom_range(11))
      0: begin
        // long line anywhere on the grid, only walked in part
        xe = rand_coord();
        ye = rand_coord();
      end
      1: begin
        xe = xs;
        ye = ys;
      end
      2: begin
        // exact diagonal, major axis falls to y
        xs = int'($urandom_range(2000)) - 1000;
        ys = int'($urandom_range(2000)) - 1000;
        d  = int'($urandom_range(40)) - 20;
        xe = xs + d;
        ye = $urandom_range(1) ? ys + d : ys - d;
      end
      default: begin
        xe = near_coord(xs);
        ye = near_coord(ys);
      end
    endcase
    adx    = (xe > xs) ? xe - xs : xs - xe;
    ady    = (ye > ys) ? ye - ys : ys - ye;
    pixels = ((adx > ady) ? adx : ady) + 1;
    case ($urandom_range(9))
      0:       steps = $urandom_range(pixels - 1);
      1:       steps = pixels + int'($urandom_range(1, 3));
      default: steps = pixels - 1;
    endcase
    if (steps > 60)
      steps = 60;
    draw_line(xs, ys, xe, ye, $urandom_range(255), $urandom_range(255),
              $urandom_range(255), steps);
  endtask

  initial begin
    int phase_base;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_kind        = KIND_START;
    in_x_start     = '0;
    in_y_start     = '0;
    in_x_end       = '0;
    in_y_end       = '0;
    in_color_red   = '0;
    in_color_green = '0;
    in_color_blue  = '0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    starts_sent    = 0;
    advances_sent  = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed lines, no idling
    // advance with no line active gives nothing
    send_advance();
    // zero-length line: one pixel, flagged last, then idle again
    draw_line(0, 0, 0, 0, 0, 0, 0, 1);
    // full-grid diagonal, cut off by the next start
    draw_line(-2048, -2048, 2047, 2047, 255, 255, 255, 3);
    // shallow line drawn right to left, endpoints get swapped
    draw_line(2047, 0, -2048, 7, 170, 85, 15, 3);
    // steep line drawn downward
    draw_line(5, 2047, -3, -2048, 1, 128, 254, 2);
    // short shallow line walked to its end plus one spare advance
    draw_line(0, 0, 3, -1, 128, 0, 255, 4);
    // zero length at the grid corner
    draw_line(-2048, 2047, -2048, 2047, 255, 0, 127, 1);
    // steep with the minor coordinate falling
    draw_line(1, 1, -1, 4, 64, 32, 16, 3);

    // random lines in four idling phases
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 62; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 62; end
        default: begin send_idle_pct = 31; stall_pct = 31; end
      endcase
      phase_base = starts_sent + advances_sent;
      while (starts_sent + advances_sent - phase_base < ITEM_TARGET / 4)
        random_line();
    end
    in_valid <= 1'b0;

    // drain, then give any stray pixel time to show up
    wait (pixels_pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("drew %0d lines with %0d advance transactions, %0d pixels checked",
             starts_sent, advances_sent, pixels_checked);
    if (mismatch_count == 0 && pixels_pending == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ----- files.f -----
design/dlr_pkg.sv
design/dlr_front.sv
design/dlr_queue.sv
design/dlr_back.sv
design/dda_line_rasterizer_unit.sv
bench/dda_pixel_checker.sv
bench/tb_dda_line_rasterizer_unit.sv
